// File: sv/ostt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ostt_pkg;

   // Table size and the width of a slot index.
   localparam int SLOTS  = 32;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // Command codes of an input word.
   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Status codes of a result word.
   localparam logic [1:0] STATUS_ADDED   = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_EXPIRED = 2'd2;
   localparam logic [1:0] STATUS_NONE    = 2'd3;

   // Sources for the result register.
   localparam logic [1:0] OSEL_ADD_OK    = 2'd0;
   localparam logic [1:0] OSEL_PEND_MORE = 2'd1;
   localparam logic [1:0] OSEL_FINAL     = 2'd2;

   typedef struct packed {
      logic        cmd;
      logic [30:0] delay_ticks;
      logic [15:0] tag;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  slot;
      logic [15:0] event_tag;
      logic [31:0] now_ticks;
      logic        last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              load_req;
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic [SLOT_W-1:0] idx;
      logic              store;
      logic              expire;
      logic              out_load;
      logic [1:0]        out_sel;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_tick;
      logic slot_used;
      logic slot_due;
      logic pend_valid;
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

// File: sv/one_shot_timer_table.sv
// Channel   Direction  Handshake              Word
// req       in         req_valid / req_stall  ostt_pkg::req_type
// rsp       out        rsp_valid / rsp_stall  ostt_pkg::rsp_type
//
// An item is accepted, the scan visits each table slot in turn, and a
// closing word ends it. An add that finds a free slot ends at that slot.
// The due/tag memory gives the scan one table entry per cycle unless held.
// Reset clears the tick counter and all used marks at once; no clearing pass.
// A stall on rsp holds the scan only when a finished word cannot move out.
`timescale 1ns / 1ps
`default_nettype none

module one_shot_timer_table (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ostt_pkg::req_type req_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ostt_pkg::rsp_type      rsp_word
);
   import ostt_pkg::*;

   ctl_cmd_type ctl;
   dp_stat_type stat;

   // Sequencer.
   ostt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   // Table storage, counter and result register.
   ostt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .ctl       (ctl),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

// File: sv/ostt_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ostt_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ostt_pkg::req_type    req_word,
   input  wire ostt_pkg::ctl_cmd_type ctl,
   output ostt_pkg::dp_stat_type     stat,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output ostt_pkg::rsp_type         rsp_word
);
   import ostt_pkg::*;

   // Entry storage: written when a timer is added, read one entry per cycle while the scan is not held.
   logic [31:0] due_mem [SLOTS];
   logic [15:0] tag_mem [SLOTS];
   logic [31:0] due_rd_ff;
   logic [15:0] tag_rd_ff;

   logic [SLOTS-1:0]  used_ff;
   logic [31:0]       tick_ff;
   req_type           req_ff;
   logic              pend_valid_ff;
   logic [SLOT_W-1:0] pend_slot_ff;
   logic [15:0]       pend_tag_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;
   logic [31:0]       diff;

   always_ff @(posedge clock) begin
      if (ctl.store) begin
         due_mem[ctl.idx] <= tick_ff + {1'b0, req_ff.delay_ticks};
         tag_mem[ctl.idx] <= req_ff.tag;
      end
      if (ctl.rd_en) begin
         due_rd_ff <= due_mem[ctl.rd_addr];
         tag_rd_ff <= tag_mem[ctl.rd_addr];
      end
   end

   // Latched input word, the held pending expiry and the result word.
   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         req_ff <= req_word;
      end
      if (ctl.expire) begin
         pend_slot_ff <= ctl.idx;
         pend_tag_ff  <= tag_rd_ff;
      end
      if (ctl.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // Control state: tick counter, used marks, pending flag, result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff       <= '0;
         used_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (ctl.load_req && req_word.cmd == CMD_TICK) begin
            tick_ff <= tick_ff + 32'd1;
         end
         if (ctl.store) begin
            used_ff[ctl.idx] <= 1'b1;
         end else if (ctl.expire) begin
            used_ff[ctl.idx] <= 1'b0;
         end
         if (ctl.expire) begin
            pend_valid_ff <= 1'b1;
         end else if (ctl.out_load && ctl.out_sel == OSEL_FINAL) begin
            pend_valid_ff <= 1'b0;
         end
         if (ctl.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Wrap-safe due test on the entry read for the current slot.
   assign diff = tick_ff - due_rd_ff;

   always_comb begin
      stat.is_tick    = (req_ff.cmd == CMD_TICK);
      stat.slot_used  = used_ff[ctl.idx];
      stat.slot_due   = !diff[31];
      stat.pend_valid = pend_valid_ff;
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Next result word.
   always_comb begin
      rsp_in.status    = STATUS_NONE;
      rsp_in.slot      = '0;
      rsp_in.event_tag = '0;
      rsp_in.now_ticks = tick_ff;
      rsp_in.last      = 1'b1;
      case (ctl.out_sel)
         OSEL_ADD_OK: begin
            rsp_in.status = STATUS_ADDED;
            rsp_in.slot   = 6'(ctl.idx);
         end
         OSEL_PEND_MORE: begin
            rsp_in.status    = STATUS_EXPIRED;
            rsp_in.slot      = 6'(pend_slot_ff);
            rsp_in.event_tag = pend_tag_ff;
            rsp_in.last      = 1'b0;
         end
         OSEL_FINAL: begin
            if (pend_valid_ff) begin
               rsp_in.status    = STATUS_EXPIRED;
               rsp_in.slot      = 6'(pend_slot_ff);
               rsp_in.event_tag = pend_tag_ff;
            end else if (req_ff.cmd == CMD_TICK) begin
               rsp_in.status = STATUS_NONE;
            end else begin
               rsp_in.status = STATUS_FULL;
            end
         end
         default: begin
            rsp_in.status = STATUS_NONE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

`default_nettype wire

// File: sv/ostt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ostt_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire ostt_pkg::dp_stat_type stat,
   output ostt_pkg::ctl_cmd_type      ctl
);
   import ostt_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_FINAL = 2'd2;

   logic [1:0]        state_ff;
   logic [1:0]        state_in;
   logic [SLOT_W-1:0] idx_ff;
   logic [SLOT_W-1:0] idx_in;
   logic [SLOT_W-1:0] idx_next;
   logic              at_last;

   assign idx_next = idx_ff + 1'b1;
   assign at_last  = (idx_ff == SLOT_W'(SLOTS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // Sequencer: accept, scan one slot per cycle unless held, final word.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      ctl          = '0;
      ctl.idx      = idx_ff;
      ctl.rd_addr  = idx_next;
      ctl.out_sel  = OSEL_FINAL;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load_req = 1'b1;
               ctl.rd_en    = 1'b1;
               ctl.rd_addr  = '0;
               idx_in       = '0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!stat.is_tick && !stat.slot_used) begin
               // First free slot takes the new timer.
               if (stat.out_free) begin
                  ctl.store    = 1'b1;
                  ctl.out_load = 1'b1;
                  ctl.out_sel  = OSEL_ADD_OK;
                  state_in     = S_IDLE;
               end
            end else if (stat.is_tick && stat.slot_used && stat.slot_due &&
                         stat.pend_valid && !stat.out_free) begin
               // Earlier expiry cannot move out yet: hold the scan.
               ctl.rd_en = 1'b0;
            end else begin
               if (stat.is_tick && stat.slot_used && stat.slot_due) begin
                  ctl.expire   = 1'b1;
                  ctl.out_load = stat.pend_valid;
                  ctl.out_sel  = OSEL_PEND_MORE;
               end
               ctl.rd_en = 1'b1;
               idx_in    = idx_next;
               if (at_last) begin
                  state_in = S_FINAL;
               end
            end
         end
         S_FINAL: begin
            if (stat.out_free) begin
               ctl.out_load = 1'b1;
               ctl.out_sel  = OSEL_FINAL;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

`default_nettype wire

// File: sv/ostt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ostt_assertions (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire ostt_pkg::req_type req_word,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire ostt_pkg::rsp_type rsp_word
);
   import ostt_pkg::*;

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // The block is busy in the cycle after it takes a word.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again straight after an accept");

   // Only expiries can be followed by more words, and only they carry a tag.
   a_non_expiry_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != STATUS_EXPIRED |->
         rsp_word.last && rsp_word.event_tag == 16'd0)
      else $error("non-expiry word not last or with a tag");

   // A full table reports slot zero.
   a_full_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == STATUS_FULL |-> rsp_word.slot == 6'd0)
      else $error("table-full word with a slot");

   // While more words of an item are due, no new input is taken.
   a_more_means_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.last |-> req_stall)
      else $error("input taken while an item still has words to give");

endmodule

bind one_shot_timer_table ostt_assertions u_ostt_assertions (.*);

`default_nettype wire
